// ===== hdl/dma_descriptor_batch_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Descriptor batch queue assertion macros
// Shared property forms for the queue checkers.
// ----------------------------------------------------------------------------
`ifndef DMA_DESCRIPTOR_BATCH_QUEUE_CORE_ASSERT_SVH
`define DMA_DESCRIPTOR_BATCH_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define DBQ_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("dbq check failed");

// next-cycle implication
`define DBQ_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("dbq check failed");

`endif

// ===== hdl/dbq_pkg.sv =====
// ----------------------------------------------------------------------------
// Descriptor batch queue package
// Types, codes and constants shared by the queue modules.
// ----------------------------------------------------------------------------
package dbq_pkg;

	localparam int ENTRIES_DEF = 32;

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 160;

	localparam logic [31:0] END_BIT   = 32'h8000_0000;
	localparam logic [31:0] LOCAL_BIT = 32'h4000_0000;
	localparam logic [31:0] BLOCK_BIT = 32'h1000_0000;

	typedef enum logic [1:0] {
		KIND_QUEUE = 2'd0,
		KIND_IDLE  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_WAITING  = 2'd1,
		ST_FINISHED = 2'd2
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [23:0] src_addr;
		logic [28:0] dest_addr;
		logic [25:0] size_bytes;
		logic        irq_local;
		logic        irq_remote;
		logic [5:0]  group_len;
		logic        chan_busy;
		logic [31:0] query_ticket;
		logic [5:0]  entry_select;
	} item_t;

	// stored descriptor, end mark kept apart
	typedef struct packed {
		logic        irq_local;
		logic [23:0] src;
		logic [23:0] words;
		logic        irq_remote;
		logic [23:0] blocks;
		logic [28:0] dest;
	} desc_word_t;

	typedef struct packed {
		logic store;
		logic end_mark;
		logic clear;
		logic rd;
	} mem_ctl_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] ticket;
		status_t     status;
		logic        launch;
		logic        launch_buffer;
		logic        rd_hit;
	} result_t;

endpackage

// ===== hdl/dbq_desc_store.sv =====
// ----------------------------------------------------------------------------
// Descriptor store
// Descriptor memory for both buffers plus end-mark banks split by slot parity.
// ----------------------------------------------------------------------------
module dbq_desc_store #(
	parameter int ENTRIES = dbq_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  dbq_pkg::mem_ctl_t                mem,
	input  logic [$clog2(2*ENTRIES)-1:0]     wr_slot,
	input  dbq_pkg::desc_word_t              wr_data,
	input  logic [$clog2(2*ENTRIES)-1:0]     rd_slot,
	output dbq_pkg::desc_word_t              rd_data,
	output logic                             rd_end
);

	localparam int AW    = $clog2(2*ENTRIES);
	localparam int DEPTH = 2*ENTRIES;

	dbq_pkg::desc_word_t desc_mem [DEPTH];
	logic                end_even [ENTRIES];
	logic                end_odd  [ENTRIES];

	logic [AW-1:0] clr_slot;
	logic          end_even_q;
	logic          end_odd_q;
	logic          rd_par_q;

	assign clr_slot = wr_slot - AW'(1);

	always_ff @(posedge clk) begin
		if (mem.store)
			desc_mem[wr_slot] <= wr_data;
		if (mem.rd)
			rd_data <= desc_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (mem.store && !wr_slot[0])
			end_even[wr_slot[AW-1:1]] <= mem.end_mark;
		else if (mem.clear && !clr_slot[0])
			end_even[clr_slot[AW-1:1]] <= 1'b0;
		if (mem.rd)
			end_even_q <= end_even[rd_slot[AW-1:1]];
	end

	always_ff @(posedge clk) begin
		if (mem.store && wr_slot[0])
			end_odd[wr_slot[AW-1:1]] <= mem.end_mark;
		else if (mem.clear && clr_slot[0])
			end_odd[clr_slot[AW-1:1]] <= 1'b0;
		if (mem.rd) begin
			end_odd_q <= end_odd[rd_slot[AW-1:1]];
			rd_par_q  <= rd_slot[0];
		end
	end

	assign rd_end = rd_par_q ? end_odd_q : end_even_q;

endmodule

// ===== hdl/dbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Queue control
// Group admission, fill and buffer state, launch decision, status query and entry read.
// ----------------------------------------------------------------------------
module dbq_ctrl #(
	parameter int ENTRIES = dbq_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dbq_pkg::item_t                   item,
	input  logic                             step,
	output dbq_pkg::result_t                 res,
	output dbq_pkg::mem_ctl_t                mem,
	output logic [$clog2(2*ENTRIES)-1:0]     wr_slot,
	output dbq_pkg::desc_word_t              wr_data,
	output logic [$clog2(2*ENTRIES)-1:0]     rd_slot
);

	localparam int FW = $clog2(ENTRIES+1);
	localparam int AW = $clog2(2*ENTRIES);

	logic [FW-1:0] fill_q,   fill_d;
	logic          active_q, active_d;
	logic [15:0]   batch_q,  batch_d;
	logic [5:0]    rem_q,    rem_d;
	logic          rej_q,    rej_d;
	logic [FW-1:0] hwm_q [2];
	logic [FW-1:0] hwm_d [2];

	dbq_pkg::mem_ctl_t mem_c;
	logic              launch_now;
	logic [31:0]       free_w;
	logic [31:0]       fill_ext;
	logic [31:0]       wr_base;
	logic [31:0]       rd_base;
	logic [4:0]        rd_idx;
	logic              rd_buf;
	logic [15:0]       qid;
	logic [26:0]       size_p3;
	logic [24:0]       words4;

	assign free_w   = 32'(ENTRIES) - 32'(fill_q);
	assign fill_ext = 32'(fill_q);
	assign rd_idx   = item.entry_select[4:0];
	assign rd_buf   = item.entry_select[5];
	assign qid      = item.query_ticket[31:16];

	assign wr_base = (active_q ? 32'(ENTRIES) : 32'd0) + fill_ext;
	assign rd_base = (rd_buf ? 32'(ENTRIES) : 32'd0) + 32'(rd_idx);
	assign wr_slot = wr_base[AW-1:0];
	assign rd_slot = rd_base[AW-1:0];

	assign size_p3            = {1'b0, item.size_bytes} + 27'd3;
	assign words4             = size_p3[26:2];
	assign wr_data.irq_local  = item.irq_local;
	assign wr_data.src        = item.src_addr;
	assign wr_data.words      = words4[23:0];
	assign wr_data.irq_remote = item.irq_remote;
	assign wr_data.blocks     = 24'(size_p3[26:4]) + {22'd0, words4[1:0]};
	assign wr_data.dest       = item.dest_addr;

	always_comb begin
		fill_d     = fill_q;
		active_d   = active_q;
		batch_d    = batch_q;
		rem_d      = rem_q;
		rej_d      = rej_q;
		hwm_d      = hwm_q;
		res        = '0;
		mem_c      = '0;
		launch_now = 1'b0;
		unique case (item.kind)
			dbq_pkg::KIND_QUEUE: begin
				if (rem_q == '0) begin
					if (item.group_len == '0 || 32'(item.group_len) > free_w) begin
						rej_d = 1'b1;
						rem_d = (item.group_len == '0) ? 6'd0 : item.group_len - 6'd1;
					end else begin
						rej_d       = 1'b0;
						rem_d       = item.group_len - 6'd1;
						res.ticket  = {batch_q, fill_ext[7:0], 2'b00, item.group_len};
						mem_c.clear = (fill_q != '0);
					end
				end else begin
					rem_d = rem_q - 6'd1;
				end
				if (!rej_d) begin
					res.accepted   = 1'b1;
					mem_c.store    = (fill_ext < 32'(ENTRIES));
					mem_c.end_mark = (rem_d == '0);
					if (mem_c.store) begin
						fill_d = fill_q + FW'(1);
						if (fill_q == hwm_q[active_q])
							hwm_d[active_q] = fill_q + FW'(1);
					end
					if (rem_d == '0 && !item.chan_busy)
						launch_now = 1'b1;
				end
			end
			dbq_pkg::KIND_IDLE: begin
				if (rem_q == '0 && !item.chan_busy && fill_q != '0)
					launch_now = 1'b1;
			end
			dbq_pkg::KIND_QUERY: begin
				res.status = dbq_pkg::ST_FINISHED;
				if (item.chan_busy) begin
					if (qid == batch_q)
						res.status = dbq_pkg::ST_WAITING;
					else if (qid + 16'd1 == batch_q)
						res.status = dbq_pkg::ST_RUNNING;
				end
			end
			dbq_pkg::KIND_READ: begin
				res.rd_hit = (32'(rd_idx) < 32'(hwm_q[rd_buf]));
				mem_c.rd   = res.rd_hit;
			end
			default: begin
				res = '0;
			end
		endcase
		if (launch_now) begin
			res.launch        = 1'b1;
			res.launch_buffer = active_q;
			batch_d           = batch_q + 16'd1;
			active_d          = ~active_q;
			fill_d            = '0;
		end
	end

	assign mem = step ? mem_c : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			active_q <= 1'b0;
			batch_q  <= '0;
			rem_q    <= '0;
			rej_q    <= 1'b0;
			hwm_q[0] <= '0;
			hwm_q[1] <= '0;
		end else if (step) begin
			fill_q   <= fill_d;
			active_q <= active_d;
			batch_q  <= batch_d;
			rem_q    <= rem_d;
			rej_q    <= rej_d;
			hwm_q[0] <= hwm_d[0];
			hwm_q[1] <= hwm_d[1];
		end
	end

endmodule

// ===== hdl/dma_descriptor_batch_queue_core.sv =====
// ----------------------------------------------------------------------------
// DMA descriptor batch queue core
// Pipeline: input beat to result beat through the input register and the result register.
// Throughput: 1 beat per cycle while the output is not stalled; at most one descriptor memory write or read per beat.
// Reset: asynchronous, clears fill, buffer, batch and group state; no clearing pass.
// ----------------------------------------------------------------------------
module dma_descriptor_batch_queue_core #(
	parameter int ENTRIES = dbq_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// src_addr, dest_addr, size_bytes, irq_local, irq_remote, group_len,
	// chan_busy, query_ticket, entry_select
	input  logic [dbq_pkg::IN_TDATA_W-1:0]     s_tdata,
	// kind
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// accepted, ticket, status, launch, launch_buffer, desc_data, desc_words,
	// desc_count, desc_addr
	output logic [dbq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int AW = $clog2(2*ENTRIES);

	dbq_pkg::item_t      item_in;
	dbq_pkg::item_t      item_s1;
	logic                valid_s1;
	dbq_pkg::result_t    res;
	dbq_pkg::result_t    res_s2;
	logic                valid_s2;
	logic                adv;
	logic                step;
	dbq_pkg::mem_ctl_t   mem;
	logic [AW-1:0]       wr_slot;
	logic [AW-1:0]       rd_slot;
	dbq_pkg::desc_word_t wr_data;
	dbq_pkg::desc_word_t rd_data;
	logic                rd_end;
	logic [31:0]         desc_data;
	logic [23:0]         desc_words;
	logic [31:0]         desc_count;
	logic [28:0]         desc_addr;

	assign item_in.kind         = dbq_pkg::kind_t'(s_tuser);
	assign item_in.src_addr     = s_tdata[23:0];
	assign item_in.dest_addr    = s_tdata[52:24];
	assign item_in.size_bytes   = s_tdata[78:53];
	assign item_in.irq_local    = s_tdata[79];
	assign item_in.irq_remote   = s_tdata[80];
	assign item_in.group_len    = s_tdata[86:81];
	assign item_in.chan_busy    = s_tdata[87];
	assign item_in.query_ticket = s_tdata[119:88];
	assign item_in.entry_select = s_tdata[125:120];

	assign adv      = !valid_s2 || m_tready;
	assign step     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_in;
		if (step)
			res_s2 <= res;
	end

	dbq_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.step    (step),
		.res     (res),
		.mem     (mem),
		.wr_slot (wr_slot),
		.wr_data (wr_data),
		.rd_slot (rd_slot)
	);

	dbq_desc_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk     (clk),
		.mem     (mem),
		.wr_slot (wr_slot),
		.wr_data (wr_data),
		.rd_slot (rd_slot),
		.rd_data (rd_data),
		.rd_end  (rd_end)
	);

	always_comb begin
		desc_data  = '0;
		desc_words = '0;
		desc_count = '0;
		desc_addr  = '0;
		if (res_s2.rd_hit) begin
			desc_data  = (rd_end ? dbq_pkg::END_BIT : 32'd0)
				| (rd_data.irq_local ? dbq_pkg::LOCAL_BIT : 32'd0)
				| 32'(rd_data.src);
			desc_words = rd_data.words;
			desc_count = (rd_data.irq_remote ? dbq_pkg::END_BIT : 32'd0)
				| dbq_pkg::BLOCK_BIT | 32'(rd_data.blocks);
			desc_addr  = rd_data.dest;
		end
	end

	assign m_tdata = {6'd0, desc_addr, desc_count, desc_words, desc_data,
		res_s2.launch_buffer, res_s2.launch, res_s2.status, res_s2.ticket,
		res_s2.accepted};

endmodule

// ===== hdl/dbq_checker.sv =====
// ----------------------------------------------------------------------------
// Descriptor batch queue checker
// Port-level properties of the queue core, bound to the top level.
// ----------------------------------------------------------------------------
`include "dma_descriptor_batch_queue_core_assert.svh"

module dbq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [dbq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	logic out_beat;
	logic exp_buf_q;

	assign out_beat = m_tvalid && m_tready;

	// track which buffer the next launch must name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_buf_q <= 1'b0;
		else if (out_beat && m_tdata[35])
			exp_buf_q <= ~exp_buf_q;
	end

	`DBQ_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`DBQ_ASSERT_IMP(a_in_open, clk, arst_n, !m_tvalid && !s_tvalid, s_tready)
	`DBQ_ASSERT_IMP(a_launch_alt, clk, arst_n, out_beat && m_tdata[35], m_tdata[36] == exp_buf_q)
	`DBQ_ASSERT_IMP(a_ticket_acc, clk, arst_n, out_beat && m_tdata[32:1] != 32'd0, m_tdata[0])
	`DBQ_ASSERT_IMP(a_status_code, clk, arst_n, out_beat, m_tdata[34:33] <= 2'(dbq_pkg::ST_FINISHED))

endmodule

bind dma_descriptor_batch_queue_core dbq_checker u_dbq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
